// ===== hdl/vn_pkg.sv =====
// Shared widths and types for the 3-D vector normalizer.
package vn_pkg;

	localparam int IN_W     = 32;
	localparam int FRAC_W   = 16;
	localparam int OUT_W    = FRAC_W + 2;
	localparam int SUM_W    = 2 * IN_W;
	localparam int ROOT_W   = IN_W;
	localparam int Q_W      = FRAC_W + 1;
	localparam int MINLEN_W = 16;
	localparam int LANES    = 3;

	typedef struct packed {
		logic [LANES-1:0]          neg;
		logic [LANES-1:0][IN_W-1:0] mag;
		logic [IN_W-1:0]           w;
	} vn_side_t;

endpackage

// ===== hdl/vn_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband.
module vn_sqrt
	import vn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [SUM_W-1:0]  radicand,
	input  vn_side_t          in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output vn_side_t          out_side
);

	logic              vld_s  [0:ROOT_W];
	logic [SUM_W-1:0]  rad_s  [0:ROOT_W];
	logic [ROOT_W+1:0] rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	vn_side_t          side_s [0:ROOT_W];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = radicand;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		logic [ROOT_W+1:0] rem_sh;
		logic [ROOT_W+1:0] trial;
		logic              fit;

		// The remainder stays below twice the partial root, so its top bits are zero here.
		assign rem_sh = {rem_s[i][ROOT_W-1:0], rad_s[i][SUM_W-1 -: 2]};
		assign trial  = {root_s[i], 2'b01};
		assign fit    = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rad_s[i+1]  <= {rad_s[i][SUM_W-3:0], 2'b00};
			rem_s[i+1]  <= fit ? (rem_sh - trial) : rem_sh;
			root_s[i+1] <= {root_s[i][ROOT_W-2:0], fit};
			side_s[i+1] <= side_s[i];
		end
	end

	assign out_valid = vld_s[ROOT_W];
	assign root      = root_s[ROOT_W];
	assign out_side  = side_s[ROOT_W];

endmodule

// ===== hdl/vn_div.sv =====
// Three parallel restoring dividers, one quotient bit per stage.
module vn_div
	import vn_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [ROOT_W-1:0]          len,
	input  logic                       in_degen,
	input  vn_side_t                   in_side,
	output logic                       out_valid,
	output logic                       out_degen,
	output logic [LANES-1:0][Q_W-1:0]  quot,
	output vn_side_t                   out_side
);

	logic              vld_s   [0:Q_W];
	logic [ROOT_W-1:0] len_s   [0:Q_W];
	logic              degen_s [0:Q_W];
	vn_side_t          side_s  [0:Q_W];
	logic [ROOT_W:0]   rem_s   [LANES][0:Q_W];
	logic [Q_W-1:0]    dbit_s  [LANES][0:Q_W];
	logic [Q_W-1:0]    q_s     [LANES][0:Q_W];

	assign vld_s[0]   = in_valid;
	assign len_s[0]   = len;
	assign degen_s[0] = in_degen;
	assign side_s[0]  = in_side;

	for (genvar l = 0; l < LANES; l++) begin : g_init
		// A component never exceeds the length, so its upper part is below the divisor.
		assign rem_s[l][0]  = {2'b00, in_side.mag[l][IN_W-1:1]};
		assign dbit_s[l][0] = {in_side.mag[l][0], {FRAC_W{1'b0}}};
		assign q_s[l][0]    = '0;
	end

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			len_s[i+1]   <= len_s[i];
			degen_s[i+1] <= degen_s[i];
			side_s[i+1]  <= side_s[i];
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [ROOT_W:0] rsh;
			logic            fit;

			assign rsh = {rem_s[l][i][ROOT_W-1:0], dbit_s[l][i][Q_W-1]};
			assign fit = (rsh >= {1'b0, len_s[i]});

			always_ff @(posedge clk) begin
				rem_s[l][i+1]  <= fit ? (rsh - {1'b0, len_s[i]}) : rsh;
				dbit_s[l][i+1] <= {dbit_s[l][i][Q_W-2:0], 1'b0};
				q_s[l][i+1]    <= {q_s[l][i][Q_W-2:0], fit};
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign quot[l] = q_s[l][Q_W];
	end

	assign out_valid = vld_s[Q_W];
	assign out_degen = degen_s[Q_W];
	assign out_side  = side_s[Q_W];

endmodule

// ===== hdl/vector_normalize_3d.sv =====
// Top level of the 3-D vector normalizer: magnitudes, squares, root, divide, sign.
// From start to done it runs through the magnitude, square and sum stages, 32 root
// stages, 1 threshold stage, 17 divide stages and 1 output register.
// Throughput is one word per cycle; busy is always low and the receiver cannot stall.
// Reset clears every valid bit and sets min_length to 1; data registers are not reset.
module vector_normalize_3d
	import vn_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [MINLEN_W-1:0]        cfg_wdata,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [IN_W-1:0]     in_x,
	input  logic signed [IN_W-1:0]     in_y,
	input  logic signed [IN_W-1:0]     in_z,
	input  logic signed [IN_W-1:0]     in_w,
	output logic                       done,
	output logic signed [OUT_W-1:0]    out_x,
	output logic signed [OUT_W-1:0]    out_y,
	output logic signed [OUT_W-1:0]    out_z,
	output logic signed [IN_W-1:0]     out_w
);

	// The pipeline never stalls, so a new word is taken every cycle.
	assign busy = 1'b0;

	logic [MINLEN_W-1:0] min_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MINLEN_W'(1);
		end else if (cfg_we) begin
			min_length_q <= cfg_wdata;
		end
	end

	// Stage 1: split each component into sign and magnitude.
	logic                     vld_s1, vld_s2, vld_s3;
	vn_side_t                 side_s1, side_s2, side_s3;
	logic [IN_W-1:0]          comp [LANES];
	logic [LANES-1:0][SUM_W-1:0] sq_s2;
	logic [SUM_W-1:0]         sum_s3;

	assign comp[0] = in_x;
	assign comp[1] = in_y;
	assign comp[2] = in_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			side_s1.neg[l] <= comp[l][IN_W-1];
			side_s1.mag[l] <= comp[l][IN_W-1] ? (~comp[l] + IN_W'(1)) : comp[l];
		end
		side_s1.w <= in_w;
	end

	// Stage 2: one 32 by 32 multiplier per component.
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			sq_s2[l] <= SUM_W'(side_s1.mag[l]) * SUM_W'(side_s1.mag[l]);
		end
		side_s2 <= side_s1;
	end

	// Stage 3: the sum of three squares stays below 2^64, so no bit is lost.
	always_ff @(posedge clk) begin
		sum_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		side_s3 <= side_s2;
	end

	// Square root pipeline gives the floor of the length in Q16.16.
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	vn_side_t          sq_side;

	vn_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.radicand  (sum_s3),
		.in_side   (side_s3),
		.out_valid (sq_vld),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	// Threshold stage: a zero length is always degenerate, whatever the register holds.
	logic              vld_s4;
	logic [ROOT_W-1:0] len_s4;
	logic              degen_s4;
	vn_side_t          side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		len_s4   <= sq_root;
		degen_s4 <= (sq_root == '0) || (sq_root < ROOT_W'(min_length_q));
		side_s4  <= sq_side;
	end

	// Divide each magnitude, shifted up by the fraction width, by the length.
	logic                      dv_vld;
	logic                      dv_degen;
	logic [LANES-1:0][Q_W-1:0] dv_quot;
	vn_side_t                  dv_side;

	vn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.len       (len_s4),
		.in_degen  (degen_s4),
		.in_side   (side_s4),
		.out_valid (dv_vld),
		.out_degen (dv_degen),
		.quot      (dv_quot),
		.out_side  (dv_side)
	);

	// Output register: clamp to 1.0, restore the sign, or substitute the fallback.
	logic [LANES-1:0][OUT_W-1:0] res;
	localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_W;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic [Q_W-1:0]   qc;
			logic [OUT_W-1:0] qe;
			qc = (dv_quot[l] > ONE_Q) ? ONE_Q : dv_quot[l];
			qe = {1'b0, qc};
			res[l] = dv_side.neg[l] ? (~qe + OUT_W'(1)) : qe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_degen) begin
			out_x <= '0;
			out_y <= OUT_W'(ONE_Q);
			out_z <= '0;
			out_w <= '0;
		end else begin
			out_x <= res[0];
			out_y <= res[1];
			out_z <= res[2];
			out_w <= dv_side.w;
		end
	end

endmodule
